// ===== design/packet_multi_pattern_window_match_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions for the pattern window matcher, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_MULTI_PATTERN_WINDOW_MATCH_MACROS_SVH
`define PACKET_MULTI_PATTERN_WINDOW_MATCH_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PMPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define PMPWM_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/pmpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmpwm_pkg
// Shared widths, codes and types of the packet pattern window matcher.
// ----------------------------------------------------------------------------
package pmpwm_pkg;

  localparam int PAT_SLOTS_DEF       = 4;
  localparam int MAX_PATTERN_LEN_DEF = 32;
  localparam int MAX_PACKET_LEN_DEF  = 65535;

  localparam int OP_W       = 2;
  localparam int SEL_W      = 2;
  localparam int BYTE_POS_W = 5;
  localparam int DATA_W     = 8;
  localparam int PLEN_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_PAT_WR   = 2'd0;
  localparam logic [OP_W-1:0] OP_LEN_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_PKT_BYTE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_DEPTH  = 2'd1;

  typedef struct packed {
    logic [CFG_W-1:0] search_offset;
    logic [CFG_W-1:0] search_depth;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]       kind;
    logic [SEL_W-1:0]      sel;
    logic [BYTE_POS_W-1:0] pos;
    logic [DATA_W-1:0]     data;
    logic [PLEN_W-1:0]     len;
    logic                  len_wr;
    logic                  len_err;
    logic                  eop;
  } cmd_t;

endpackage

// ===== design/pmpwm_front.sv =====
// ----------------------------------------------------------------------------
// pmpwm_front
// Request decode: drop unknown and out-of-range loads, saturate and check
// pattern lengths against the search depth, push commands to the queue.
// ----------------------------------------------------------------------------
module pmpwm_front #(
  parameter int PAT_SLOTS       = pmpwm_pkg::PAT_SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = pmpwm_pkg::MAX_PATTERN_LEN_DEF
) (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pmpwm_pkg::OP_W-1:0]       in_op,
  input  logic [pmpwm_pkg::SEL_W-1:0]      in_pattern_sel,
  input  logic [pmpwm_pkg::BYTE_POS_W-1:0] in_byte_pos,
  input  logic [pmpwm_pkg::DATA_W-1:0]     in_data_byte,
  input  logic [pmpwm_pkg::PLEN_W-1:0]     in_pattern_len,
  input  logic                             in_end_of_packet,
  input  pmpwm_pkg::cfg_t                  cfg,
  input  logic                             q_full,
  output logic                             q_push,
  output pmpwm_pkg::cmd_t                  q_cmd
);

  logic                          sel_ok;
  logic                          pos_ok;
  logic                          keep;
  logic [pmpwm_pkg::PLEN_W-1:0]  sat_len;

  assign in_stall = q_full;
  assign sel_ok   = int'(in_pattern_sel) < PAT_SLOTS;
  assign pos_ok   = int'(in_byte_pos) < MAX_PATTERN_LEN;
  assign sat_len  = (int'(in_pattern_len) > MAX_PATTERN_LEN) ?
                    pmpwm_pkg::PLEN_W'(MAX_PATTERN_LEN) : in_pattern_len;

  always_comb begin
    case (in_op)
      pmpwm_pkg::OP_PAT_WR:   keep = sel_ok && pos_ok;
      pmpwm_pkg::OP_LEN_SET:  keep = 1'b1;
      pmpwm_pkg::OP_PKT_BYTE: keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.kind    = in_op;
    q_cmd.sel     = in_pattern_sel;
    q_cmd.pos     = in_byte_pos;
    q_cmd.data    = in_data_byte;
    q_cmd.len     = sat_len;
    q_cmd.len_err = (cfg.search_depth != '0) &&
                    (pmpwm_pkg::CFG_W'(sat_len) > cfg.search_depth);
    q_cmd.len_wr  = !q_cmd.len_err && sel_ok;
    q_cmd.eop     = in_end_of_packet && (in_op == pmpwm_pkg::OP_PKT_BYTE);
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

// ===== design/pmpwm_queue.sv =====
// ----------------------------------------------------------------------------
// pmpwm_queue
// Two-entry command queue between decode and execute.
// ----------------------------------------------------------------------------
`include "packet_multi_pattern_window_match_macros.svh"

module pmpwm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pmpwm_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            pop_valid,
  output pmpwm_pkg::cmd_t pop_cmd,
  input  logic            pop
);

  pmpwm_pkg::cmd_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `PMPWM_NEVER(a_q_overflow, push && full, "queue push while full")
  `PMPWM_ASSERT(a_q_ptrs, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "queue pointers out of step")

endmodule

// ===== design/pmpwm_back.sv =====
// ----------------------------------------------------------------------------
// pmpwm_back
// Execute: pattern table, window history, per-pattern tail compare and the
// result register.
// ----------------------------------------------------------------------------
`include "packet_multi_pattern_window_match_macros.svh"

module pmpwm_back #(
  parameter int PAT_SLOTS       = pmpwm_pkg::PAT_SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = pmpwm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int MAX_PACKET_LEN  = pmpwm_pkg::MAX_PACKET_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pmpwm_pkg::cfg_t                cfg,
  input  logic                           q_valid,
  input  pmpwm_pkg::cmd_t                q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_matched,
  output logic [pmpwm_pkg::STATUS_W-1:0] out_status
);

  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int POS_W = $clog2(MAX_PACKET_LEN + 1);
  localparam int WIN_W = MAX_PATTERN_LEN * pmpwm_pkg::DATA_W;

  logic [WIN_W-1:0]                pat_r   [PAT_SLOTS];
  logic [LEN_W-1:0]                len_r   [PAT_SLOTS];
  logic [LEN_W-1:0]                len_nxt [PAT_SLOTS];
  logic [WIN_W-1:0]                hist_r, hist_nxt;
  logic [LEN_W-1:0]                fill_r, fill_nxt;
  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic                            seen_r, seen_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_matched_r, out_matched_nxt;
  logic [pmpwm_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic                            is_byte;
  logic                            is_len;
  logic                            is_pat;
  logic                            gives_result;
  logic                            pos_live;
  logic                            in_win;
  logic [pmpwm_pkg::CFG_W-1:0]     pos_ext;
  logic [pmpwm_pkg::CFG_W-1:0]     rel;
  logic [WIN_W+pmpwm_pkg::DATA_W-1:0] shift_ext;
  logic [WIN_W-1:0]                hist_shift;
  logic [LEN_W-1:0]                fill_inc;
  logic [LEN_W-1:0]                amt_v  [PAT_SLOTS];
  logic [WIN_W-1:0]                win_v  [PAT_SLOTS];
  logic [WIN_W-1:0]                mask_v [PAT_SLOTS];
  logic [PAT_SLOTS-1:0]            hit;
  logic                            any_len;

  assign is_byte      = (q_cmd.kind == pmpwm_pkg::OP_PKT_BYTE);
  assign is_len       = (q_cmd.kind == pmpwm_pkg::OP_LEN_SET);
  assign is_pat       = (q_cmd.kind == pmpwm_pkg::OP_PAT_WR);
  assign gives_result = is_len || (is_byte && q_cmd.eop);
  assign q_pop        = q_valid && (!gives_result || !out_valid_r || !out_stall);

  // window position
  assign pos_live = (pos_r < POS_W'(MAX_PACKET_LEN));
  assign pos_ext  = pmpwm_pkg::CFG_W'(pos_r);
  assign rel      = pos_ext - cfg.search_offset;
  assign in_win   = pos_live && (pos_ext >= cfg.search_offset) &&
                    ((cfg.search_depth == '0) || (rel < cfg.search_depth));

  // oldest byte at the low end, newest at the top
  assign shift_ext  = {q_cmd.data, hist_r};
  assign hist_shift = shift_ext[WIN_W+pmpwm_pkg::DATA_W-1:pmpwm_pkg::DATA_W];
  assign fill_inc   = (fill_r == LEN_W'(MAX_PATTERN_LEN)) ? fill_r : fill_r + 1'b1;

  // align the newest len bytes with pattern byte 0 and compare
  always_comb begin
    for (int s = 0; s < PAT_SLOTS; s++) begin
      amt_v[s] = LEN_W'(MAX_PATTERN_LEN) - len_r[s];
      win_v[s] = hist_shift >> {amt_v[s], 3'b000};
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        mask_v[s][i*pmpwm_pkg::DATA_W +: pmpwm_pkg::DATA_W] =
          {pmpwm_pkg::DATA_W{LEN_W'(i) < len_r[s]}};
      end
      hit[s] = (len_r[s] != '0) && (len_r[s] <= fill_inc) &&
               (((win_v[s] ^ pat_r[s]) & mask_v[s]) == '0);
    end
  end

  always_comb begin
    any_len = 1'b0;
    for (int s = 0; s < PAT_SLOTS; s++) begin
      if (len_r[s] != '0) begin
        any_len = 1'b1;
      end
    end
  end

  always_comb begin
    for (int s = 0; s < PAT_SLOTS; s++) begin
      len_nxt[s] = len_r[s];
    end
    hist_nxt        = hist_r;
    fill_nxt        = fill_r;
    pos_nxt         = pos_r;
    seen_nxt        = seen_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_matched_nxt = out_matched_r;
    out_status_nxt  = out_status_r;
    if (q_pop) begin
      case (q_cmd.kind)
        pmpwm_pkg::OP_LEN_SET: begin
          if (q_cmd.len_wr) begin
            for (int s = 0; s < PAT_SLOTS; s++) begin
              if (int'(q_cmd.sel) == s) begin
                len_nxt[s] = LEN_W'(q_cmd.len);
              end
            end
          end
          out_valid_nxt   = 1'b1;
          out_matched_nxt = 1'b0;
          out_status_nxt  = q_cmd.len_err ? pmpwm_pkg::ST_LEN_ERR : pmpwm_pkg::ST_OK;
        end
        pmpwm_pkg::OP_PKT_BYTE: begin
          if (in_win) begin
            hist_nxt = hist_shift;
            fill_nxt = fill_inc;
            if (|hit) begin
              seen_nxt = 1'b1;
            end
          end
          if (pos_live) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (q_cmd.eop) begin
            out_valid_nxt   = 1'b1;
            out_matched_nxt = any_len && seen_nxt;
            out_status_nxt  = any_len ? pmpwm_pkg::ST_OK : pmpwm_pkg::ST_NO_PAT;
            fill_nxt        = '0;
            pos_nxt         = '0;
            seen_nxt        = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PAT_SLOTS; s++) begin
        len_r[s] <= '0;
      end
      fill_r      <= '0;
      pos_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int s = 0; s < PAT_SLOTS; s++) begin
        len_r[s] <= len_nxt[s];
      end
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hist_r        <= hist_nxt;
    out_matched_r <= out_matched_nxt;
    out_status_r  <= out_status_nxt;
    if (q_pop && is_pat) begin
      for (int s = 0; s < PAT_SLOTS; s++) begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          if ((int'(q_cmd.sel) == s) && (int'(q_cmd.pos) == i)) begin
            pat_r[s][i*pmpwm_pkg::DATA_W +: pmpwm_pkg::DATA_W] <= q_cmd.data;
          end
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;

  `PMPWM_NEVER(a_fill_bound, fill_r > LEN_W'(MAX_PATTERN_LEN), "window fill above pattern size")
  `PMPWM_NEVER(a_seen_fill, seen_r && (fill_r == '0), "match flagged with empty window")
  `PMPWM_ASSERT(a_eop_clear, (q_pop && is_byte && q_cmd.eop) |=> (out_valid_r && (fill_r == '0) && (pos_r == '0) && !seen_r), "packet state not cleared at packet end")

endmodule

// ===== design/packet_multi_pattern_window_match.sv =====
// A request is written into the command queue; execute then takes it and registers its result in the result register.
// Throughput: one request per cycle while the queue is not full; the execute stage compares every pattern per byte.
// A two-entry queue lets decode keep taking requests while a result waits to be taken.
// Reset clears lengths, window fill, position and match flag, queue and the search registers.
// Pattern bytes are undefined until written.
// ----------------------------------------------------------------------------
// packet_multi_pattern_window_match
// Packet payload filter matching up to PAT_SLOTS byte patterns inside a window.
// ----------------------------------------------------------------------------
module packet_multi_pattern_window_match #(
  parameter int PAT_SLOTS       = pmpwm_pkg::PAT_SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = pmpwm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int MAX_PACKET_LEN  = pmpwm_pkg::MAX_PACKET_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pmpwm_pkg::OP_W-1:0]       in_op,
  input  logic [pmpwm_pkg::SEL_W-1:0]      in_pattern_sel,
  input  logic [pmpwm_pkg::BYTE_POS_W-1:0] in_byte_pos,
  input  logic [pmpwm_pkg::DATA_W-1:0]     in_data_byte,
  input  logic [pmpwm_pkg::PLEN_W-1:0]     in_pattern_len,
  input  logic                             in_end_of_packet,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_matched,
  output logic [pmpwm_pkg::STATUS_W-1:0]   out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmpwm_pkg::CFG_W-1:0]      cfg_data
);

  pmpwm_pkg::cfg_t cfg_r, cfg_nxt;
  logic            q_full;
  logic            q_push;
  pmpwm_pkg::cmd_t push_cmd;
  logic            q_valid;
  pmpwm_pkg::cmd_t pop_cmd;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmpwm_pkg::CFG_SEARCH_OFFSET: cfg_nxt.search_offset = cfg_data;
        pmpwm_pkg::CFG_SEARCH_DEPTH:  cfg_nxt.search_depth  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pmpwm_front #(
    .PAT_SLOTS       (PAT_SLOTS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pattern_sel   (in_pattern_sel),
    .in_byte_pos      (in_byte_pos),
    .in_data_byte     (in_data_byte),
    .in_pattern_len   (in_pattern_len),
    .in_end_of_packet (in_end_of_packet),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  pmpwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd),
    .pop       (q_pop)
  );

  pmpwm_back #(
    .PAT_SLOTS       (PAT_SLOTS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .MAX_PACKET_LEN  (MAX_PACKET_LEN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_matched (out_matched),
    .out_status  (out_status)
  );

endmodule
